// ===== sv/zpf_pkg.sv =====
package zpf_pkg;

  // Default sizes
  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_TAPS    = 8;

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Coefficient banks
  localparam logic [1:0] BANK_B  = 2'd0;
  localparam logic [1:0] BANK_A  = 2'd1;
  localparam logic [1:0] BANK_ZI = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  // Taps register
  localparam int          TAPS_W     = 4;
  localparam logic [3:0]  TAPS_RESET = 4'd3;

  // Rounding bias for Q20.40 -> Q16.16
  localparam logic signed [63:0] ROUND_BIAS = 64'sd8388608;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         coef_bank;
    logic [2:0]         coef_index;
    logic signed [31:0] value;
    logic               last;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic [1:0]         status;
  } out_item_t;

  // Source of the next filter input
  typedef enum logic [1:0] {
    SRC_MID = 2'd0,
    SRC_LO  = 2'd1,
    SRC_HI  = 2'd2,
    SRC_FWD = 2'd3
  } src_t;

  // MAC operand pair
  typedef enum logic [1:0] {
    SEL_B = 2'd0,
    SEL_A = 2'd1,
    SEL_Z = 2'd2
  } sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic coef_we;
    logic store;
    logic store_first;
    logic rd_out;
    logic out_load;
    logic set_short;
    logic set_done;
    logic hist_clr;
    logic rd_in;
    logic rd_fwd;
    logic load_x;
    logic first_step;
    src_t src;
    logic acc_clr;
    logic mac_en;
    sel_t sel;
    logic round;
    logic fwd_we;
    logic out_we;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/zpf_ctrl.sv =====
module zpf_ctrl #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS,
  localparam int EDGE  = 3 * (MAX_TAPS - 1),
  localparam int AW    = $clog2(MAX_SAMPLES),
  localparam int FA_W  = $clog2(MAX_SAMPLES + EDGE),
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int TIW   = $clog2(MAX_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [zpf_pkg::TAPS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  zpf_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output zpf_pkg::cmd_t                 cmd,
  output logic [AW-1:0]                 in_addr,
  output logic [FA_W-1:0]               fa_addr,
  output logic [AW-1:0]                 oa_addr,
  output logic [TIW-1:0]                coef_sel,
  output logic [CNT_W-1:0]              count
);

  localparam int K_W  = $clog2(MAX_SAMPLES + 2 * EDGE + 1);
  localparam int TN_W = $clog2(MAX_TAPS + 1);
  localparam int SW   = $clog2(2 * MAX_TAPS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_START = 8'b00000100,
    S_FETCH = 8'b00001000,
    S_WAIT  = 8'b00010000,
    S_MAC   = 8'b00100000,
    S_DRAIN = 8'b01000000,
    S_ROUND = 8'b10000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [zpf_pkg::TAPS_W-1:0] taps_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [K_W-1:0]             k_r, k_nxt;
  logic [SW-1:0]              i_r, i_nxt;
  logic                       pass_r, pass_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [TN_W-1:0] nt;
  logic [K_W-1:0]  nf, n_k, k_last, ra, short_thr;
  logic            accept, mac_last;

  // Clamp taps, derive edge length and pass bounds
  always_comb begin
    if (taps_r < 4'd2) nt = TN_W'(2);
    else if (32'(taps_r) > MAX_TAPS) nt = TN_W'(MAX_TAPS);
    else nt = TN_W'(taps_r);
    nf        = (K_W'(nt) - K_W'(1)) * K_W'(3);
    n_k       = K_W'(count_r);
    short_thr = K_W'(nt) * K_W'(3) - K_W'(2);
    k_last    = pass_r ? (n_k + nf - K_W'(1)) : (n_k + nf + nf - K_W'(1));
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign count     = count_r;

  // Read address and source of the filter input at position k
  always_comb begin
    cmd = '0;
    cmd.src = zpf_pkg::SRC_FWD;
    ra = n_k + nf - K_W'(1) - k_r;
    if (!pass_r) begin
      if (k_r < nf) begin
        cmd.src = zpf_pkg::SRC_LO;
        ra = nf - k_r;
      end else if (k_r < nf + n_k) begin
        cmd.src = zpf_pkg::SRC_MID;
        ra = k_r - nf;
      end else begin
        cmd.src = zpf_pkg::SRC_HI;
        ra = n_k - K_W'(2) - (k_r - nf - n_k);
      end
    end
    in_addr = (state_r == S_IDLE) ? AW'(count_r) : AW'(ra);
    fa_addr = pass_r ? FA_W'(ra) : FA_W'(k_r - nf);
    oa_addr = AW'(n_k + nf - K_W'(1) - k_r);

    // MAC step decode: b terms, a terms, then the initial-state term
    mac_last = (32'(i_r) == 32'(nt) * 2 - 1);
    if (32'(i_r) < 32'(nt)) begin
      cmd.sel  = zpf_pkg::SEL_B;
      coef_sel = TIW'(i_r);
      cmd.mac_en = (state_r == S_MAC);
    end else if (32'(i_r) < 32'(nt) * 2 - 1) begin
      cmd.sel  = zpf_pkg::SEL_A;
      coef_sel = TIW'(32'(i_r) - 32'(nt) + 1);
      cmd.mac_en = (state_r == S_MAC);
    end else begin
      cmd.sel  = zpf_pkg::SEL_Z;
      coef_sel = TIW'(k_r);
      cmd.mac_en = (state_r == S_MAC) && (32'(k_r) + 1 < 32'(nt));
    end

    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            zpf_pkg::KIND_LOAD: cmd.coef_we = 1'b1;
            zpf_pkg::KIND_SAMPLE: begin
              if (32'(count_r) < MAX_SAMPLES) begin
                cmd.store       = 1'b1;
                cmd.store_first = (count_r == '0);
                count_nxt       = count_r + CNT_W'(1);
              end
              if (in_item.last) state_nxt = S_START;
            end
            zpf_pkg::KIND_READ: begin
              cmd.rd_out = 1'b1;
              state_nxt  = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_START: begin
        if (n_k <= short_thr) begin
          cmd.set_short = 1'b1;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end else begin
          cmd.hist_clr = 1'b1;
          k_nxt        = '0;
          pass_nxt     = 1'b0;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_in  = !pass_r;
        cmd.rd_fwd = pass_r;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        cmd.load_x     = 1'b1;
        cmd.first_step = (k_r == '0);
        cmd.acc_clr    = 1'b1;
        i_nxt          = '0;
        state_nxt      = S_MAC;
      end
      S_MAC: begin
        i_nxt = i_r + SW'(1);
        if (mac_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_ROUND;
      S_ROUND: begin
        cmd.round  = 1'b1;
        cmd.fwd_we = !pass_r && (k_r >= nf);
        cmd.out_we = pass_r && (k_r >= nf);
        if (k_r == k_last) begin
          if (!pass_r) begin
            pass_nxt     = 1'b1;
            k_nxt        = '0;
            cmd.hist_clr = 1'b1;
            state_nxt    = S_FETCH;
          end else begin
            cmd.set_done = 1'b1;
            count_nxt    = '0;
            state_nxt    = S_IDLE;
          end
        end else begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taps_r      <= zpf_pkg::TAPS_RESET;
      count_r     <= '0;
      k_r         <= '0;
      i_r         <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) taps_r <= cfg_data;
    end
  end

endmodule

// ===== sv/zpf_dp.sv =====
module zpf_dp #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS,
  localparam int EDGE  = 3 * (MAX_TAPS - 1),
  localparam int AW    = $clog2(MAX_SAMPLES),
  localparam int FA_W  = $clog2(MAX_SAMPLES + EDGE),
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int TIW   = $clog2(MAX_TAPS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zpf_pkg::in_item_t  in_item,
  input  zpf_pkg::cmd_t      cmd,
  input  logic [AW-1:0]      in_addr,
  input  logic [FA_W-1:0]    fa_addr,
  input  logic [AW-1:0]      oa_addr,
  input  logic [TIW-1:0]     coef_sel,
  input  logic [CNT_W-1:0]   count,
  output zpf_pkg::out_item_t out_item
);

  // Record, forward-pass and result memories
  logic signed [31:0] in_mem  [MAX_SAMPLES];
  logic signed [31:0] fwd_mem [MAX_SAMPLES + EDGE];
  logic signed [31:0] out_mem [MAX_SAMPLES];
  logic signed [31:0] in_rdata_r, fwd_rdata_r, out_rdata_r;

  // Coefficient banks, history lines
  logic signed [31:0] b_r [MAX_TAPS];
  logic signed [31:0] a_r [MAX_TAPS];
  logic signed [31:0] zi_r [MAX_TAPS];
  logic signed [31:0] xh_r [MAX_TAPS];
  logic signed [31:0] yh_r [MAX_TAPS];

  logic signed [31:0] first_r, lastv_r, scale_r;
  logic signed [63:0] prod_r, acc_r;
  logic               prod_v_r, prod_sub_r;
  logic [1:0]         stat_r;
  logic [CNT_W-1:0]   len_r;
  logic [9:0]         ridx_r;
  zpf_pkg::out_item_t out_item_r;

  logic signed [31:0] x, y, op_c, op_d;
  logic signed [63:0] prod_w, rsum;

  assign out_item = out_item_r;

  // Filter input: stored sample, odd reflection at either edge, or forward value
  always_comb begin
    case (cmd.src)
      zpf_pkg::SRC_MID: x = in_rdata_r;
      zpf_pkg::SRC_LO:  x = zpf_pkg::sat32((64'(first_r) <<< 1) - 64'(in_rdata_r));
      zpf_pkg::SRC_HI:  x = zpf_pkg::sat32((64'(lastv_r) <<< 1) - 64'(in_rdata_r));
      default:          x = fwd_rdata_r;
    endcase
  end

  // MAC operand select
  always_comb begin
    case (cmd.sel)
      zpf_pkg::SEL_B: begin
        op_c = b_r[coef_sel];
        op_d = xh_r[coef_sel];
      end
      zpf_pkg::SEL_A: begin
        op_c = a_r[coef_sel];
        op_d = yh_r[coef_sel];
      end
      default: begin
        op_c = zi_r[coef_sel];
        op_d = scale_r;
      end
    endcase
    prod_w = op_c * op_d;
    rsum   = acc_r + zpf_pkg::ROUND_BIAS;
    y      = zpf_pkg::sat32(rsum >>> 24);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.store) in_mem[in_addr] <= in_item.value;
    if (cmd.rd_in) in_rdata_r <= in_mem[in_addr];
    if (cmd.fwd_we) fwd_mem[fa_addr] <= y;
    if (cmd.rd_fwd) fwd_rdata_r <= fwd_mem[fa_addr];
    if (cmd.out_we) out_mem[oa_addr] <= y;
    if (cmd.rd_out) out_rdata_r <= out_mem[AW'(in_item.read_index)];
  end

  // Coefficient banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        b_r[j]  <= '0;
        a_r[j]  <= '0;
        zi_r[j] <= '0;
      end
    end else if (cmd.coef_we && (32'(in_item.coef_index) < MAX_TAPS)) begin
      case (in_item.coef_bank)
        zpf_pkg::BANK_B:  b_r[TIW'(in_item.coef_index)]  <= in_item.value;
        zpf_pkg::BANK_A:  a_r[TIW'(in_item.coef_index)]  <= in_item.value;
        zpf_pkg::BANK_ZI: zi_r[TIW'(in_item.coef_index)] <= in_item.value;
        default: ;
      endcase
    end
  end

  // Record edges, history, scale, MAC pipeline
  always_ff @(posedge clk) begin
    if (cmd.store_first) first_r <= in_item.value;
    if (cmd.store) lastv_r <= in_item.value;
    if (cmd.load_x && cmd.first_step) scale_r <= x;
    if (cmd.hist_clr) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        xh_r[j] <= '0;
        yh_r[j] <= '0;
      end
    end else begin
      if (cmd.load_x) begin
        xh_r[0] <= x;
        for (int j = 1; j < MAX_TAPS; j++) xh_r[j] <= xh_r[j-1];
      end
      if (cmd.round) begin
        yh_r[1] <= y;
        for (int j = 2; j < MAX_TAPS; j++) yh_r[j] <= yh_r[j-1];
      end
    end
    prod_r     <= prod_w;
    prod_sub_r <= (cmd.sel == zpf_pkg::SEL_A);
    if (cmd.acc_clr) acc_r <= '0;
    else if (prod_v_r) acc_r <= prod_sub_r ? acc_r - (prod_r >>> 4) : acc_r + (prod_r >>> 4);
  end

  // Record status and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      stat_r   <= zpf_pkg::STAT_NONE;
      len_r    <= '0;
    end else begin
      prod_v_r <= cmd.mac_en;
      if (cmd.set_short) begin
        stat_r <= zpf_pkg::STAT_SHORT;
        len_r  <= '0;
      end else if (cmd.set_done) begin
        stat_r <= zpf_pkg::STAT_OK;
        len_r  <= count;
      end
    end
    if (cmd.rd_out) ridx_r <= in_item.read_index;
    if (cmd.out_load) begin
      if (stat_r != zpf_pkg::STAT_OK) begin
        out_item_r.filtered_value <= '0;
        out_item_r.status         <= stat_r;
      end else if (32'(ridx_r) < 32'(len_r)) begin
        out_item_r.filtered_value <= out_rdata_r;
        out_item_r.status         <= zpf_pkg::STAT_OK;
      end else begin
        out_item_r.filtered_value <= '0;
        out_item_r.status         <= zpf_pkg::STAT_NONE;
      end
    end
  end

endmodule

// ===== sv/zero_phase_iir_filter.sv =====
// Zero-phase forward-backward IIR filter over one stored record.
// Input items (in_valid/in_ready) load a coefficient (b, a or zi bank),
// write a sample of the record, or read a filtered sample. The sample item
// with last set starts filtering: the record is extended by 3*(taps-1)
// odd-reflected samples at each end, filtered forward, then in reverse.
// cfg_we/cfg_data write taps, used clamped to 2..MAX_TAPS; the user must
// write them only while the block is idle; the block does not enforce it.
// A read item's result passes the memory read register, then the output
// register. Filtering runs sample by sample on the single shared MAC;
// in_ready stays low meanwhile.
// Reads beyond the record return status 1; a record of 3*taps-2 samples or
// fewer returns status 2.
// Results sit in an output register; items are still accepted while it waits,
// and a further read, once accepted, holds until out_ready frees the register.
// Reset clears coefficients, taps (3), sample count and sets status 1; the
// sample memories are not cleared.
module zero_phase_iir_filter #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [zpf_pkg::TAPS_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  zpf_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output zpf_pkg::out_item_t         out_item
);

  localparam int EDGE  = 3 * (MAX_TAPS - 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int FA_W  = $clog2(MAX_SAMPLES + EDGE);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int TIW   = $clog2(MAX_TAPS);

  zpf_pkg::cmd_t    cmd;
  logic [AW-1:0]    in_addr, oa_addr;
  logic [FA_W-1:0]  fa_addr;
  logic [TIW-1:0]   coef_sel;
  logic [CNT_W-1:0] count;

  zpf_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
    .in_addr(in_addr), .fa_addr(fa_addr), .oa_addr(oa_addr),
    .coef_sel(coef_sel), .count(count)
  );

  zpf_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_TAPS(MAX_TAPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
    .in_addr(in_addr), .fa_addr(fa_addr), .oa_addr(oa_addr),
    .coef_sel(coef_sel), .count(count), .out_item(out_item)
  );

  // Forward and reverse passes never write in the same cycle
  a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.fwd_we && cmd.out_we)) else $error("both pass writes active");

  // No item is taken while a filter step completes
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> !in_ready) else $error("item accepted during filtering");

  // A loaded result is presented on the next cycle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid) else $error("result not presented");

  // Memory reads of the two passes and the result read are exclusive
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_in, cmd.rd_fwd, cmd.rd_out})) else $error("read conflict");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import zpf_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [3:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  zero_phase_iir_filter dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  localparam int LIMIT = 3000000;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] rec_in [MAX_SAMPLES];
  logic signed [31:0] fwd_buf [MAX_SAMPLES + 21];
  logic signed [31:0] filt_out [MAX_SAMPLES];
  logic signed [31:0] coef_b [MAX_TAPS];
  logic signed [31:0] coef_a [MAX_TAPS];
  logic signed [31:0] coef_zi [MAX_TAPS];
  logic signed [31:0] x_hist [MAX_TAPS];
  logic signed [31:0] y_hist [MAX_TAPS];
  int unsigned        n_stored;
  logic [1:0]         rec_status;
  int unsigned        rec_len;
  logic [3:0]         taps_reg;

  out_item_t pending_reads[$];
  int        errors;
  int        cycles;
  int        n_reads;
  int        n_records;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] prod_q40(input logic signed [31:0] c,
                                                  input logic signed [31:0] s);
    logic signed [63:0] p;
    p = 64'(c) * 64'(s);
    return p >>> 4;
  endfunction

  // one filter step: shift in x, return y
  function automatic logic signed [31:0] iir_step(input logic signed [31:0] x,
      input int nt, input int n, input logic signed [31:0] scale);
    logic signed [63:0] acc;
    logic signed [31:0] y;
    acc = 0;
    for (int j = MAX_TAPS - 1; j >= 1; j--) x_hist[j] = x_hist[j-1];
    x_hist[0] = x;
    for (int j = 0; j < nt; j++) acc += prod_q40(coef_b[j], x_hist[j]);
    for (int j = 1; j < nt; j++) acc -= prod_q40(coef_a[j], y_hist[j]);
    if (n + 1 < nt) acc += prod_q40(coef_zi[n], scale);
    y = clamp32((acc + ROUND_BIAS) >>> 24);
    for (int j = MAX_TAPS - 1; j >= 2; j--) y_hist[j] = y_hist[j-1];
    y_hist[1] = y;
    return y;
  endfunction

  function automatic logic signed [31:0] extended(input int k, input int n, input int nf);
    if (k < nf) return clamp32(2 * 64'(rec_in[0]) - 64'(rec_in[nf-k]));
    if (k < nf + n) return rec_in[k-nf];
    return clamp32(2 * 64'(rec_in[n-1]) - 64'(rec_in[n-2-(k-nf-n)]));
  endfunction

  function automatic void clear_hist();
    for (int j = 0; j < MAX_TAPS; j++) begin
      x_hist[j] = 0;
      y_hist[j] = 0;
    end
  endfunction

  function automatic void filter_record();
    int nt, nf, n, len;
    logic signed [31:0] scale, y;
    nt = taps_reg < 2 ? 2 : (taps_reg > MAX_TAPS ? MAX_TAPS : int'(taps_reg));
    nf = 3 * (nt - 1);
    n = n_stored;
    n_records++;
    if (n <= 3 * nt - 2) begin
      rec_status = STAT_SHORT;
      rec_len = 0;
      return;
    end
    len = n + 2 * nf;
    scale = extended(0, n, nf);
    clear_hist();
    for (int k = 0; k < len; k++) begin
      y = iir_step(extended(k, n, nf), nt, k, scale);
      if (k >= nf) fwd_buf[k-nf] = y;
    end
    len = n + nf;
    scale = fwd_buf[len-1];
    clear_hist();
    for (int m = 0; m < len; m++) begin
      y = iir_step(fwd_buf[len-1-m], nt, m, scale);
      if (m >= nf) filt_out[len-1-m] = y;
    end
    rec_status = STAT_OK;
    rec_len = n;
  endfunction

  // apply one accepted item to the predictor
  function automatic void predict_item(input in_item_t it);
    out_item_t r;
    case (it.kind)
      KIND_LOAD: begin
        if (it.coef_bank == BANK_B) coef_b[it.coef_index] = it.value;
        else if (it.coef_bank == BANK_A) coef_a[it.coef_index] = it.value;
        else if (it.coef_bank == BANK_ZI) coef_zi[it.coef_index] = it.value;
      end
      KIND_SAMPLE: begin
        if (n_stored < MAX_SAMPLES) begin
          rec_in[n_stored] = it.value;
          n_stored++;
        end
        if (it.last) begin
          filter_record();
          n_stored = 0;
        end
      end
      KIND_READ: begin
        if (rec_status != STAT_OK) begin
          r.filtered_value = 0;
          r.status = rec_status;
        end else if (it.read_index < rec_len) begin
          r.filtered_value = filt_out[it.read_index];
          r.status = STAT_OK;
        end else begin
          r.filtered_value = 0;
          r.status = STAT_NONE;
        end
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t, %0d results outstanding", $time, pending_reads.size());
      $display("FAIL");
      $finish;
    end
  end

  // result checking and output stalls
  int stall_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, out_item);
        errors <= errors + 1;
      end else begin
        out_item_t e;
        e = pending_reads.pop_front();
        if (e.filtered_value !== out_item.filtered_value ||
            e.status !== out_item.status) begin
          $display("%0t: mismatch expected value %h status %0d, got value %h status %0d",
                   $time, e.filtered_value, e.status,
                   out_item.filtered_value, out_item.status);
          errors <= errors + 1;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // send one item and wait for acceptance, with optional gap first;
  // valid stays high into the next item when there is no gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain_and_config(input logic [3:0] t);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    taps_reg = t;
  endtask

  function automatic in_item_t mk(input logic [1:0] k, input logic [1:0] b,
      input logic [2:0] i, input logic [31:0] v, input logic l, input logic [9:0] r);
    in_item_t it;
    it.kind = k; it.coef_bank = b; it.coef_index = i;
    it.value = v; it.last = l; it.read_index = r;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 4;
    endcase
  endfunction

  // a small coefficient in Q4.28, keeps the filters mostly stable
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000) >>> 2;
  endfunction

  // one record: coefficients, samples, then reads
  task automatic run_record(input int nsamp, input int nreads);
    int nt;
    nt = taps_reg < 2 ? 2 : (taps_reg > MAX_TAPS ? MAX_TAPS : int'(taps_reg));
    for (int j = 0; j < nt; j++) begin
      send_item(mk(KIND_LOAD, BANK_B, 3'(j), rand_coef(), 1'($urandom), 10'($urandom)));
      send_item(mk(KIND_LOAD, BANK_A, 3'(j), rand_coef(), 1'($urandom), 10'($urandom)));
      send_item(mk(KIND_LOAD, BANK_ZI, 3'(j), rand_coef(), 1'($urandom), 10'($urandom)));
    end
    for (int s = 0; s < nsamp; s++)
      send_item(mk(KIND_SAMPLE, 2'($urandom), 3'($urandom), rand_value(), s == nsamp - 1,
                   10'($urandom)));
    for (int r = 0; r < nreads; r++) begin
      n_reads++;
      send_item(mk(KIND_READ, 2'($urandom), 3'($urandom), $urandom, 1'($urandom),
                   ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                               : 10'($urandom_range(0, nsamp))));
    end
  endtask

  typedef struct {
    in_item_t   it;
    logic       check;
    out_item_t  exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    out_item_t e;
    out_item_t got;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    n_reads = 0;
    n_records = 0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      coef_b[j] = 0; coef_a[j] = 0; coef_zi[j] = 0;
    end
    n_stored = 0;
    rec_status = STAT_NONE;
    rec_len = 0;
    taps_reg = TAPS_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; checked rows carry an expected result
    dir_rows.push_back('{mk(KIND_READ, BANK_B, 0, 0, 0, 0), 1, '{0, STAT_NONE}});
    dir_rows.push_back('{mk(KIND_READ, BANK_B, 0, 0, 0, 10'h3ff), 1, '{0, STAT_NONE}});
    dir_rows.push_back('{mk(2'd3, BANK_A, 1, 32'h7fffffff, 1, 5), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_LOAD, 2'd3, 7, 32'h12345678, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_LOAD, BANK_B, 0, 32'h10000000, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_LOAD, BANK_B, 7, 32'h80000000, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_LOAD, BANK_A, 7, 32'h7fffffff, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_LOAD, BANK_ZI, 0, 32'h01000000, 0, 0), 0, '{0, 0}});
    // short record of 3 samples at taps 3
    dir_rows.push_back('{mk(KIND_SAMPLE, 0, 0, 32'h7fffffff, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_SAMPLE, 0, 0, 32'h80000000, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_SAMPLE, 0, 0, 32'h00010000, 1, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0), 1, '{0, STAT_SHORT}});
    // unit b0 with a small initial state, 8 samples with extremes at both ends
    for (int s = 0; s < 8; s++)
      dir_rows.push_back('{mk(KIND_SAMPLE, 0, 0, (s == 0) ? 32'h7fffffff :
                              (s == 7) ? 32'h80000000 : 32'(s) <<< 16, s == 7, 0),
                           0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 2), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 7), 0, '{0, 0}});
    dir_rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 8), 1, '{0, STAT_NONE}});
    // unknown kind gives no result
    dir_rows.push_back('{mk(2'd3, 3, 7, 32'hffffffff, 1, 10'h3ff), 0, '{0, 0}});

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].check && dir_rows[i].exp !== pending_reads[$]) begin
        e = pending_reads[$];
        $display("%0t: directed row %0d expected value %h status %0d, predictor %h %0d",
                 $time, i, dir_rows[i].exp.filtered_value, dir_rows[i].exp.status,
                 e.filtered_value, e.status);
        errors++;
      end
    end

    // random records across taps settings, extremes included
    drain_and_config(4'd2);
    run_record(5, 6);
    run_record(12, 10);
    drain_and_config(4'd8);
    run_record(22, 6);
    run_record(30, 12);
    drain_and_config(4'd0);
    run_record(9, 8);
    drain_and_config(4'd15);
    run_record(25, 8);
    drain_and_config(4'd1);
    run_record(1, 2);
    for (int r = 0; r < 3; r++) begin
      drain_and_config(4'($urandom_range(2, 8)));
      run_record($urandom_range(3, 40), $urandom_range(4, 12));
    end
    drain_and_config(4'd4);
    run_record(16, 8);

    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d records and %0d read items over taps 0..15.", n_records, n_reads);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
